/* rtl/b64enc_pkg.sv */
package b64enc_pkg;

    typedef logic [5:0] sextet_t;
    typedef logic [6:0] char_t;
    typedef logic [1:0] phase_t;

    // Position within the current three-byte group
    localparam phase_t PHASE_ZERO = 2'd0;
    localparam phase_t PHASE_ONE  = 2'd1;
    localparam phase_t PHASE_TWO  = 2'd2;

    // Configuration register indexes
    localparam int           CFG_INDEX_W = 2;
    localparam logic [1:0]   CFG_SYM62   = 2'd0;
    localparam logic [1:0]   CFG_SYM63   = 2'd1;

    localparam char_t SYM62_RESET = 7'd126;  // '~'
    localparam char_t SYM63_RESET = 7'd94;   // '^'
    localparam char_t PAD_CHAR    = 7'd61;   // '='

    // Everything one byte produces, ahead of symbol mapping
    typedef struct packed {
        sextet_t [3:0] sym;
        logic    [3:0] pad;
        logic    [1:0] last_idx;
        phase_t        phase_next;
        logic    [3:0] left_next;
    } slice_t;

endpackage

/* rtl/b64enc_slice.sv */
module b64enc_slice
(
    input  b64enc_pkg::phase_t phase,
    input  logic [3:0]         leftover,
    input  logic [7:0]         data_byte,
    input  logic               final_byte,
    output b64enc_pkg::slice_t slice
);

    always_comb
    begin
        slice = '0;
        case (phase)
            b64enc_pkg::PHASE_ONE:
            begin
                slice.sym[0]     = {leftover[1:0], data_byte[7:4]};
                slice.left_next  = data_byte[3:0];
                slice.phase_next = b64enc_pkg::PHASE_TWO;
                slice.last_idx   = 2'd0;
                if (final_byte)
                begin
                    slice.sym[1]   = {data_byte[3:0], 2'b00};
                    slice.pad[2]   = 1'b1;
                    slice.last_idx = 2'd2;
                end
            end
            b64enc_pkg::PHASE_TWO:
            begin
                slice.sym[0]     = {leftover, data_byte[7:6]};
                slice.sym[1]     = data_byte[5:0];
                slice.left_next  = 4'd0;
                slice.phase_next = b64enc_pkg::PHASE_ZERO;
                slice.last_idx   = 2'd1;
            end
            default:
            begin
                // unreachable phase three folds into phase zero
                slice.sym[0]     = data_byte[7:2];
                slice.left_next  = {2'b00, data_byte[1:0]};
                slice.phase_next = b64enc_pkg::PHASE_ONE;
                slice.last_idx   = 2'd0;
                if (final_byte)
                begin
                    slice.sym[1]   = {data_byte[1:0], 4'b0000};
                    slice.pad[2]   = 1'b1;
                    slice.pad[3]   = 1'b1;
                    slice.last_idx = 2'd3;
                end
            end
        endcase
        if (final_byte)
        begin
            slice.phase_next = b64enc_pkg::PHASE_ZERO;
            slice.left_next  = 4'd0;
        end
    end

endmodule

/* rtl/b64enc_map.sv */
module b64enc_map
(
    input  b64enc_pkg::sextet_t sextet,
    input  logic                pad,
    input  b64enc_pkg::char_t   sym62,
    input  b64enc_pkg::char_t   sym63,
    output b64enc_pkg::char_t   char_code
);

    logic [6:0] wide;

    assign wide = {1'b0, sextet};

    always_comb
    begin
        if (pad)
            char_code = b64enc_pkg::PAD_CHAR;
        else if (sextet < 6'd26)
            char_code = wide + 7'd65;          // 'A'..'Z'
        else if (sextet < 6'd52)
            char_code = wide + 7'd71;          // 'a'..'z'
        else if (sextet < 6'd62)
            char_code = wide - 7'd4;           // '0'..'9'
        else if (sextet == 6'd62)
            char_code = sym62;
        else
            char_code = sym63;
    end

endmodule

/* rtl/base64_stream_encoder.sv */
// Streaming base64 encoder, one raw byte per input item.
//
// Input channel: in_valid / in_stall with data_byte and final_byte. Raise
// final_byte on the last byte of a message; the encoder then flushes the
// partial symbol and pads with '=' to a full group of four.
// Output channel: out_valid / out_stall with out_char (ASCII), run_last on
// the last symbol caused by a byte, message_end on the last symbol of the
// message.
// Config channel: cfg_valid / cfg_ready, always ready. cfg_index 0 sets the
// symbol for value 62, index 1 for value 63; other indexes are ignored.
// Write only while the encoder is idle.
//
// The first symbol of a byte goes from the symbol buffer into the output
// register once that register is free. Throughput: one symbol per cycle
// while the receiver does not stall, set by the single output register; a byte
// yields one to four symbols (one or two in a running message, four per three
// bytes on average).
// Reset clears the group position, the pending items and restores the
// symbols '~' and '^'. While the receiver stalls, the output item holds and
// the symbol buffer fills; the input stalls once the buffer cannot drain.
module base64_stream_encoder
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [7:0]                              data_byte,
    input  logic                                    final_byte,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [6:0]                              out_char,
    output logic                                    run_last,
    output logic                                    message_end,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [b64enc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [6:0]                              cfg_data
);

    // configuration
    b64enc_pkg::char_t sym62_reg;
    b64enc_pkg::char_t sym63_reg;

    // group state
    b64enc_pkg::phase_t phase_reg;
    logic [3:0]         left_reg;

    // symbol buffer for the byte in progress
    b64enc_pkg::char_t  work_char_reg [4];
    logic               work_valid_reg;
    logic [1:0]         work_idx_reg;
    logic [1:0]         work_last_reg;
    logic               work_fin_reg;

    // output register
    logic               out_valid_reg;
    b64enc_pkg::char_t  out_char_reg;
    logic               run_last_reg;
    logic               message_end_reg;

    b64enc_pkg::slice_t slice;
    b64enc_pkg::char_t  mapped [4];

    logic out_free;
    logic work_advance;
    logic work_done;
    logic in_acc;

    b64enc_slice u_slice
    (
        .phase      (phase_reg),
        .leftover   (left_reg),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .slice      (slice)
    );

    for (genvar g = 0; g < 4; g++)
    begin : g_map
        b64enc_map u_map
        (
            .sextet    (slice.sym[g]),
            .pad       (slice.pad[g]),
            .sym62     (sym62_reg),
            .sym63     (sym63_reg),
            .char_code (mapped[g])
        );
    end

    // Drain one symbol per cycle into the output register while it is free;
    // take the next byte as the last symbol of the current one moves out.
    assign out_free     = !out_valid_reg || !out_stall;
    assign work_advance = work_valid_reg && out_free;
    assign work_done    = work_advance && (work_idx_reg == work_last_reg);
    assign in_stall     = work_valid_reg && !work_done;
    assign in_acc       = in_valid && !in_stall;

    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign out_char    = out_char_reg;
    assign run_last    = run_last_reg;
    assign message_end = message_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym62_reg <= b64enc_pkg::SYM62_RESET;
            sym63_reg <= b64enc_pkg::SYM63_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                b64enc_pkg::CFG_SYM62: sym62_reg <= cfg_data;
                b64enc_pkg::CFG_SYM63: sym63_reg <= cfg_data;
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= b64enc_pkg::PHASE_ZERO;
            left_reg       <= 4'd0;
            work_valid_reg <= 1'b0;
            work_idx_reg   <= 2'd0;
        end
        else if (in_acc)
        begin
            phase_reg      <= slice.phase_next;
            left_reg       <= slice.left_next;
            work_valid_reg <= 1'b1;
            work_idx_reg   <= 2'd0;
        end
        else if (work_advance)
        begin
            if (work_done)
                work_valid_reg <= 1'b0;
            else
                work_idx_reg <= work_idx_reg + 2'd1;
        end
    end

    // symbol payload, loaded with each accepted byte
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            for (int i = 0; i < 4; i++)
            begin
                work_char_reg[i] <= mapped[i];
            end
            work_last_reg <= slice.last_idx;
            work_fin_reg  <= final_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (work_advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (work_advance)
        begin
            out_char_reg    <= work_char_reg[work_idx_reg];
            run_last_reg    <= work_idx_reg == work_last_reg;
            message_end_reg <= (work_idx_reg == work_last_reg) && work_fin_reg;
        end
    end

    // The input only stalls while a byte is still being drained.
    a_stall_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> work_valid_reg)
        else $error("input stalled with empty symbol buffer");

    // The drain index never passes the last symbol of the byte.
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        work_valid_reg |-> (work_idx_reg <= work_last_reg))
        else $error("symbol index beyond last symbol");

    // A final byte always restarts the group.
    a_final_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && final_byte) |=> (phase_reg == b64enc_pkg::PHASE_ZERO && left_reg == 4'd0))
        else $error("group not restarted after final byte");

    // Phase three is never entered.
    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("illegal group phase");

    // End of message only marks the last symbol of a byte.
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && message_end_reg) |-> run_last_reg)
        else $error("message end without run last");

endmodule
